// File: rtl/met_pkg.sv
// shared types and constants for the mandelbrot escape-time block
`default_nettype none

package met_pkg;

   // field and register widths
   localparam int PIXEL_WIDTH     = 12;
   localparam int COUNT_WIDTH     = 16;
   localparam int SHADE_WIDTH     = 16;
   localparam int BASE_WIDTH      = 48;
   localparam int STEP_WIDTH      = 47;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 48;

   // step is split in two for the coordinate multipliers
   localparam int STEP_SPLIT = 24;
   // width that holds base + pixel * step without overflow
   localparam int COORD_SUM_WIDTH = 64;

   // divider widths for the brightness quotient
   localparam int DIV_WIDTH     = COUNT_WIDTH + 1;
   localparam int DIV_CNT_WIDTH = 4;

   // register reset values (-2.5, -1.1 and the default view steps)
   localparam logic signed [BASE_WIDTH-1:0] X_MIN_RESET = -48'sd171798691840;
   localparam logic signed [BASE_WIDTH-1:0] Y_MIN_RESET = -48'sd75591424410;
   localparam logic [STEP_WIDTH-1:0] STEP_X_RESET = 47'd401533003;
   localparam logic [STEP_WIDTH-1:0] STEP_Y_RESET = 47'd252392068;
   localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = 16'd5000;

   // shading constants
   localparam logic [DIV_WIDTH-1:0]   SHADE_OFFSET    = 17'd50;
   localparam logic [COUNT_WIDTH-1:0] HIGHLIGHT_LIMIT = 16'd4950;
   localparam logic [SHADE_WIDTH-1:0] FULL_SHADE      = 16'hFFFF;

   // register map
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_X_MIN    = 3'd0,
      CSR_Y_MIN    = 3'd1,
      CSR_STEP_X   = 3'd2,
      CSR_STEP_Y   = 3'd3,
      CSR_MAX_ITER = 3'd4
   } csr_index_type;

   // request and response payloads
   typedef struct packed {
      logic [PIXEL_WIDTH-1:0] pixel_col;
      logic [PIXEL_WIDTH-1:0] pixel_row;
   } met_req_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] escape_count;
      logic                   inside_set;
      logic [SHADE_WIDTH-1:0] brightness;
      logic                   highlight;
   } met_rsp_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COORD_MUL,
      ST_COORD_SUM,
      ST_ABS,
      ST_MUL,
      ST_SUM,
      ST_SAT,
      ST_TEST,
      ST_DIVIDE,
      ST_DONE
   } met_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic capture;
      logic coord_mul;
      logic coord_load;
      logic abs_load;
      logic mul;
      logic sum;
      logic sat;
      logic update;
      logic set_inside;
   } met_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic limit_zero;
      logic escaped;
      logic last_iter;
   } met_status_type;

endpackage

`default_nettype wire

// File: rtl/met_div.sv
// restoring divider for the brightness fraction n * 2^16 / (n + 50)
`default_nettype none

module met_div
   import met_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [COUNT_WIDTH-1:0] count,
   output logic                        busy,
   output logic [SHADE_WIDTH-1:0]      quotient
);

   logic                     busy_ff, busy_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [DIV_WIDTH-1:0]     rem_ff, rem_in;
   logic [DIV_WIDTH-1:0]     den_ff, den_in;
   logic [SHADE_WIDTH-1:0]   quo_ff, quo_in;
   logic [DIV_WIDTH:0]       trial;
   logic                     fits;

   // one quotient bit per cycle, numerator is always below the divisor
   always_comb begin
      trial   = {rem_ff, 1'b0};
      fits    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, count};
         den_in  = {1'b0, count} + SHADE_OFFSET;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_WIDTH'(trial - {1'b0, den_ff}) : DIV_WIDTH'(trial);
         quo_in = {quo_ff[SHADE_WIDTH-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (&cnt_ff) begin
            busy_in = 1'b0;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// File: rtl/met_datapath.sv
// coordinate mapping, split multipliers and z update for the escape iteration
`default_nettype none

module met_datapath
   import met_pkg::*;
#(
   parameter int FRAC_BITS  = 36,
   parameter int COORD_BITS = 12
) (
   input  wire logic                   clock,
   input  wire met_cmd_type            cmd,
   input  wire met_req_type            req_data,
   input  wire logic [BASE_WIDTH-1:0]  x_min,
   input  wire logic [BASE_WIDTH-1:0]  y_min,
   input  wire logic [STEP_WIDTH-1:0]  step_x,
   input  wire logic [STEP_WIDTH-1:0]  step_y,
   input  wire logic [COUNT_WIDTH-1:0] max_iterations,
   output met_status_type              status,
   output logic [COUNT_WIDTH-1:0]      count_out,
   output logic                        inside_out
);

   // value width, limb split and full product width
   localparam int ZW = (COORD_BITS + FRAC_BITS > 62) ? 62 : COORD_BITS + FRAC_BITS;
   localparam int LW = (ZW + 1) / 2;
   localparam int HW = ZW - LW;
   localparam int PW = 2 * ZW;
   localparam int LO_W = PIXEL_WIDTH + STEP_SPLIT;
   localparam int HI_W = PIXEL_WIDTH + STEP_WIDTH - STEP_SPLIT;
   localparam int SW = COORD_SUM_WIDTH;

   localparam logic [ZW-1:0] ZMAX = {1'b0, {(ZW-1){1'b1}}};
   localparam logic [ZW-1:0] ZMIN = {1'b1, {(ZW-1){1'b0}}};
   localparam logic [ZW:0]   FOUR = {{(ZW-2){1'b0}}, 3'b100} << FRAC_BITS;

   // clamp a coordinate sum to the value range
   function automatic logic [ZW-1:0] clamp_coord(input logic [SW-1:0] s);
      logic ones;
      logic zeros;
      ones  = &s[SW-1:ZW-1];
      zeros = ~|s[SW-1:ZW-1];
      if (ones || zeros) begin
         return s[ZW-1:0];
      end
      return s[SW-1] ? ZMIN : ZMAX;
   endfunction

   // clamp an update sum two bits wider than the value range
   function automatic logic [ZW-1:0] clamp_update(input logic [ZW+1:0] s);
      logic ones;
      logic zeros;
      ones  = &s[ZW+1:ZW-1];
      zeros = ~|s[ZW+1:ZW-1];
      if (ones || zeros) begin
         return s[ZW-1:0];
      end
      return s[ZW+1] ? ZMIN : ZMAX;
   endfunction

   // drop the fraction bits of a product magnitude and limit it
   function automatic logic [ZW-1:0] scale_product(input logic [PW-1:0] p);
      logic [PW-1:0] q;
      q = p >> FRAC_BITS;
      if (|q[PW-1:ZW-1]) begin
         return ZMAX;
      end
      return q[ZW-1:0];
   endfunction

   logic [PIXEL_WIDTH-1:0] col_ff, row_ff;
   logic [LO_W-1:0]        cx_lo_ff, cy_lo_ff, cx_lo_in, cy_lo_in;
   logic [HI_W-1:0]        cx_hi_ff, cy_hi_ff, cx_hi_in, cy_hi_in;
   logic [SW-1:0]          cx_sum, cy_sum;
   logic [ZW-1:0]          cr_ff, ci_ff, cr_in, ci_in;
   logic [ZW-1:0]          zr_ff, zi_ff, zr_in, zi_in;
   logic [ZW-1:0]          ar_ff, ai_ff, ar_in, ai_in;
   logic                   neg_ff, neg_in;
   logic [LW-1:0]          arl, ail;
   logic [HW-1:0]          arh, aih;
   logic [2*LW-1:0]        rr_ll_ff, ii_ll_ff, ri_ll_ff, rr_ll_in, ii_ll_in, ri_ll_in;
   logic [ZW-1:0]          rr_lh_ff, ii_lh_ff, ri_lh_ff, ri_hl_ff;
   logic [ZW-1:0]          rr_lh_in, ii_lh_in, ri_lh_in, ri_hl_in;
   logic [2*HW-1:0]        rr_hh_ff, ii_hh_ff, ri_hh_ff, rr_hh_in, ii_hh_in, ri_hh_in;
   logic [PW-1:0]          rr_p_ff, ii_p_ff, ri_p_ff, rr_p_in, ii_p_in, ri_p_in;
   logic [ZW-1:0]          rr_ff, ii_ff, ri_ff, rr_in, ii_in, ri_in;
   logic [ZW-1:0]          ri_mag;
   logic [ZW:0]            mag_sum;
   logic [ZW+1:0]          zr_sum, zi_sum;
   logic [COUNT_WIDTH-1:0] k_ff, k_in;
   logic                   inside_ff, inside_in;

   // pixel times step, in two halves per axis
   always_comb begin
      cx_lo_in = LO_W'(col_ff) * LO_W'(step_x[STEP_SPLIT-1:0]);
      cx_hi_in = HI_W'(col_ff) * HI_W'(step_x[STEP_WIDTH-1:STEP_SPLIT]);
      cy_lo_in = LO_W'(row_ff) * LO_W'(step_y[STEP_SPLIT-1:0]);
      cy_hi_in = HI_W'(row_ff) * HI_W'(step_y[STEP_WIDTH-1:STEP_SPLIT]);
   end

   // base plus offset, clamped to the value range
   always_comb begin
      cx_sum = {{(SW-BASE_WIDTH){x_min[BASE_WIDTH-1]}}, x_min}
             + (SW'(cx_hi_ff) << STEP_SPLIT) + SW'(cx_lo_ff);
      cy_sum = {{(SW-BASE_WIDTH){y_min[BASE_WIDTH-1]}}, y_min}
             + (SW'(cy_hi_ff) << STEP_SPLIT) + SW'(cy_lo_ff);
      cr_in  = clamp_coord(cx_sum);
      ci_in  = clamp_coord(cy_sum);
   end

   // magnitudes and product sign of z
   always_comb begin
      ar_in  = zr_ff[ZW-1] ? ZW'(~zr_ff + 1'b1) : zr_ff;
      ai_in  = zi_ff[ZW-1] ? ZW'(~zi_ff + 1'b1) : zi_ff;
      neg_in = zr_ff[ZW-1] ^ zi_ff[ZW-1];
   end

   // partial products of the limbs
   always_comb begin
      arl      = ar_ff[LW-1:0];
      arh      = ar_ff[ZW-1:LW];
      ail      = ai_ff[LW-1:0];
      aih      = ai_ff[ZW-1:LW];
      rr_ll_in = (2*LW)'(arl) * (2*LW)'(arl);
      rr_lh_in = ZW'(arl) * ZW'(arh);
      rr_hh_in = (2*HW)'(arh) * (2*HW)'(arh);
      ii_ll_in = (2*LW)'(ail) * (2*LW)'(ail);
      ii_lh_in = ZW'(ail) * ZW'(aih);
      ii_hh_in = (2*HW)'(aih) * (2*HW)'(aih);
      ri_ll_in = (2*LW)'(arl) * (2*LW)'(ail);
      ri_lh_in = ZW'(arl) * ZW'(aih);
      ri_hl_in = ZW'(arh) * ZW'(ail);
      ri_hh_in = (2*HW)'(arh) * (2*HW)'(aih);
   end

   // recombine partial products into full magnitudes
   always_comb begin
      rr_p_in = (PW'(rr_hh_ff) << (2*LW)) + (PW'(rr_lh_ff) << (LW+1)) + PW'(rr_ll_ff);
      ii_p_in = (PW'(ii_hh_ff) << (2*LW)) + (PW'(ii_lh_ff) << (LW+1)) + PW'(ii_ll_ff);
      ri_p_in = (PW'(ri_hh_ff) << (2*LW)) + (PW'(ri_lh_ff) << LW)
              + (PW'(ri_hl_ff) << LW) + PW'(ri_ll_ff);
   end

   // scale, limit and sign the products
   always_comb begin
      rr_in  = scale_product(rr_p_ff);
      ii_in  = scale_product(ii_p_ff);
      ri_mag = scale_product(ri_p_ff);
      ri_in  = neg_ff ? ZW'(~ri_mag + 1'b1) : ri_mag;
   end

   // escape test and next z
   always_comb begin
      mag_sum = {1'b0, rr_ff} + {1'b0, ii_ff};
      zr_sum  = {2'b00, rr_ff} - {2'b00, ii_ff} + {{2{cr_ff[ZW-1]}}, cr_ff};
      zi_sum  = {ri_ff[ZW-1], ri_ff, 1'b0} + {{2{ci_ff[ZW-1]}}, ci_ff};
      zr_in   = cmd.coord_load ? cr_in : clamp_update(zr_sum);
      zi_in   = cmd.coord_load ? ci_in : clamp_update(zi_sum);
   end

   // iteration counter and inside flag
   always_comb begin
      k_in      = k_ff;
      inside_in = inside_ff;
      if (cmd.coord_load) begin
         k_in = '0;
      end else if (cmd.update) begin
         k_in = k_ff + 1'b1;
      end
      if (cmd.capture) begin
         inside_in = 1'b0;
      end else if (cmd.set_inside) begin
         inside_in = 1'b1;
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         col_ff <= req_data.pixel_col;
         row_ff <= req_data.pixel_row;
      end
      if (cmd.coord_mul) begin
         cx_lo_ff <= cx_lo_in;
         cx_hi_ff <= cx_hi_in;
         cy_lo_ff <= cy_lo_in;
         cy_hi_ff <= cy_hi_in;
      end
      if (cmd.coord_load) begin
         cr_ff <= cr_in;
         ci_ff <= ci_in;
      end
      if (cmd.coord_load || cmd.update) begin
         zr_ff <= zr_in;
         zi_ff <= zi_in;
      end
      if (cmd.abs_load) begin
         ar_ff  <= ar_in;
         ai_ff  <= ai_in;
         neg_ff <= neg_in;
      end
      if (cmd.mul) begin
         rr_ll_ff <= rr_ll_in;
         rr_lh_ff <= rr_lh_in;
         rr_hh_ff <= rr_hh_in;
         ii_ll_ff <= ii_ll_in;
         ii_lh_ff <= ii_lh_in;
         ii_hh_ff <= ii_hh_in;
         ri_ll_ff <= ri_ll_in;
         ri_lh_ff <= ri_lh_in;
         ri_hl_ff <= ri_hl_in;
         ri_hh_ff <= ri_hh_in;
      end
      if (cmd.sum) begin
         rr_p_ff <= rr_p_in;
         ii_p_ff <= ii_p_in;
         ri_p_ff <= ri_p_in;
      end
      if (cmd.sat) begin
         rr_ff <= rr_in;
         ii_ff <= ii_in;
         ri_ff <= ri_in;
      end
      k_ff      <= k_in;
      inside_ff <= inside_in;
   end

   // status and result
   assign status.limit_zero = (max_iterations == '0);
   assign status.escaped    = (mag_sum > FOUR);
   assign status.last_iter  = (({1'b0, k_ff} + 1'b1) == {1'b0, max_iterations});
   assign count_out         = inside_ff ? max_iterations : k_ff;
   assign inside_out        = inside_ff;

endmodule

`default_nettype wire

// File: rtl/met_ctrl.sv
// sequencer for one pixel: coordinate, iteration loop, shading, response
`default_nettype none

module met_ctrl
   import met_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   output logic                req_ready,
   input  wire met_status_type status,
   input  wire logic           div_busy,
   input  wire logic           out_free,
   output met_cmd_type         cmd,
   output logic                div_start,
   output logic                rsp_load
);

   met_state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_COORD_MUL;
            end
         end
         ST_COORD_MUL: begin
            state_in = ST_COORD_SUM;
         end
         ST_COORD_SUM: begin
            state_in = status.limit_zero ? ST_DONE : ST_ABS;
         end
         ST_ABS: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_SUM;
         end
         ST_SUM: begin
            state_in = ST_SAT;
         end
         ST_SAT: begin
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (status.escaped) begin
               state_in = ST_DIVIDE;
            end else if (status.last_iter) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_ABS;
            end
         end
         ST_DIVIDE: begin
            if (!div_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_COORD_MUL: begin
            cmd.coord_mul = 1'b1;
         end
         ST_COORD_SUM: begin
            cmd.coord_load = 1'b1;
            cmd.set_inside = status.limit_zero;
         end
         ST_ABS: begin
            cmd.abs_load = 1'b1;
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
         end
         ST_SUM: begin
            cmd.sum = 1'b1;
         end
         ST_SAT: begin
            cmd.sat = 1'b1;
         end
         ST_TEST: begin
            div_start      = status.escaped;
            cmd.set_inside = !status.escaped && status.last_iter;
            cmd.update     = !status.escaped && !status.last_iter;
         end
         ST_DIVIDE: begin
         end
         ST_DONE: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/mandelbrot_escape_time_top.sv
// top level of the mandelbrot escape-time pixel evaluator
`default_nettype none

// Evaluates one pixel per request: maps (pixel_col, pixel_row) to the point
// c = (x_min + col*step_x) + j*(y_min + row*step_y) in signed fixed point with
// COORD_BITS integer and FRAC_BITS fraction bits (Q12.36 by default), iterates
// z = z*z + c from zero until |z|^2 > 4 or max_iterations is reached, and
// returns the escape index, an inside flag, a brightness n/(n+50) as a 0.16
// fraction (full scale when inside) and a highlight flag. All intermediate
// values saturate. One pixel is in flight at a time; a new request is taken
// while the previous response still waits at the output. Each iteration runs
// through the limb-multiplier array in the steps magnitude, partial
// products, recombine, scale, and test and update; an escaping pixel then
// goes through the shading divide before its response is loaded, while an
// inside pixel is answered without it. The user must write registers through
// the csr port only while no pixel is in work; the block does not enforce it.

module mandelbrot_escape_time_top
   import met_pkg::*;
#(
   parameter int FRAC_BITS  = 36,
   parameter int COORD_BITS = 12
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire met_req_type                req_data,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output met_rsp_type                     rsp_data,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   logic [BASE_WIDTH-1:0]  x_min_ff, y_min_ff;
   logic [STEP_WIDTH-1:0]  step_x_ff, step_y_ff;
   logic [COUNT_WIDTH-1:0] max_iter_ff;
   met_cmd_type            cmd;
   met_status_type         status;
   logic                   div_start, div_busy, rsp_load, out_free;
   logic [SHADE_WIDTH-1:0] quotient;
   logic [COUNT_WIDTH-1:0] count;
   logic                   inside_flag;
   met_rsp_type            rsp_ff, rsp_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff    <= X_MIN_RESET;
         y_min_ff    <= Y_MIN_RESET;
         step_x_ff   <= STEP_X_RESET;
         step_y_ff   <= STEP_Y_RESET;
         max_iter_ff <= MAX_ITER_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_X_MIN:    x_min_ff    <= csr_data[BASE_WIDTH-1:0];
            CSR_Y_MIN:    y_min_ff    <= csr_data[BASE_WIDTH-1:0];
            CSR_STEP_X:   step_x_ff   <= csr_data[STEP_WIDTH-1:0];
            CSR_STEP_Y:   step_y_ff   <= csr_data[STEP_WIDTH-1:0];
            CSR_MAX_ITER: max_iter_ff <= csr_data[COUNT_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   met_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .div_busy  (div_busy),
      .out_free  (out_free),
      .cmd       (cmd),
      .div_start (div_start),
      .rsp_load  (rsp_load)
   );

   // iteration datapath
   met_datapath #(
      .FRAC_BITS  (FRAC_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .cmd            (cmd),
      .req_data       (req_data),
      .x_min          (x_min_ff),
      .y_min          (y_min_ff),
      .step_x         (step_x_ff),
      .step_y         (step_y_ff),
      .max_iterations (max_iter_ff),
      .status         (status),
      .count_out      (count),
      .inside_out     (inside_flag)
   );

   // shading divider
   met_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .count    (count),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // response register
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in.escape_count = count;
      rsp_in.inside_set   = inside_flag;
      rsp_in.brightness   = inside_flag ? FULL_SHADE : quotient;
      rsp_in.highlight    = inside_flag || (count > HIGHLIGHT_LIMIT);
      rsp_valid_in        = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
